@@ rtl/core/icv_pkg.sv @@
// Package for the 2D convolution core: sizes, codes, queue entry and window types.
// Helper functions map kernel positions onto window slots and coefficients.
// No dependencies.
package icv_pkg;

  localparam int MaxWidth    = 1024;
  localparam int MaxHeight   = 1024;
  localparam int MaxKernel   = 7;
  localparam int PixelBits   = 16;
  localparam int CoefBits    = 16;
  localparam int CoefDepth   = MaxKernel * MaxKernel;
  localparam int CoefIdxBits = 6;
  localparam int ColBits     = $clog2(MaxWidth);
  localparam int RowBits     = $clog2(MaxHeight) + 1;
  localparam int DimBits     = 11;
  localparam int KhBits      = 2;
  localparam int ShiftBits   = 5;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 11;
  localparam int NumBanks    = MaxKernel;
  localparam int BankBits    = $clog2(NumBanks);
  localparam int PosBits     = 21;
  localparam int OutPosBits  = 20;
  localparam int DelayBits   = 13;
  localparam int ProdBits    = PixelBits + CoefBits;
  localparam int RowSumBits  = ProdBits + 3;
  localparam int SumBits     = ProdBits + 6;
  localparam int FifoDepth   = 4;
  localparam int FifoPtrBits = $clog2(FifoDepth);
  localparam int FifoCntBits = FifoPtrBits + 1;
  localparam int PixMaxInt   = 2 ** (PixelBits - 1) - 1;
  localparam int PixMinInt   = -(2 ** (PixelBits - 1));

  localparam logic [DimBits-1:0]   WidthReset  = DimBits'(1024);
  localparam logic [DimBits-1:0]   HeightReset = DimBits'(1024);
  localparam logic [KhBits-1:0]    KhalfReset  = KhBits'(1);
  localparam logic [ShiftBits-1:0] ShiftReset  = ShiftBits'(14);

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_KHALF  = 2'd2,
    CFG_SHIFT  = 2'd3
  } cfg_idx_e;

  typedef logic [MaxKernel-1:0] mask_t;

  // One queued operation for the back end.
  typedef struct packed {
    logic                   is_load;
    logic                   is_adv;
    logic                   do_write;
    logic                   emit;
    logic                   last;
    logic [PixelBits-1:0]   data;
    logic [CoefIdxBits-1:0] cidx;
    logic [ColBits-1:0]     vcol;
    logic [BankBits-1:0]    vbank;
    mask_t                  row_mask;
    mask_t                  col_mask;
  } op_t;

  typedef logic [NumBanks-1:0][PixelBits-1:0] col_t;
  typedef col_t [MaxKernel-1:0]               win_t;

  // Coefficient slot of kernel position (ky, kx) for a given radius.
  function automatic logic [CoefIdxBits-1:0] coef_pos(input logic [KhBits-1:0] kh,
                                                      input int ky, input int kx);
    int side;
    int p;
    side = 2 * int'(kh) + 1;
    p = 0;
    if (ky < side && kx < side) begin
      p = ky * side + kx;
    end
    return CoefIdxBits'(p);
  endfunction

  // Window column holding kernel column kx; newest column sits in the top slot.
  function automatic logic [BankBits-1:0] win_slot(input logic [KhBits-1:0] kh, input int kx);
    int s;
    s = MaxKernel - 1 - 2 * int'(kh) + kx;
    if (s > MaxKernel - 1) begin
      s = MaxKernel - 1;
    end
    return BankBits'(s);
  endfunction

  // Column entry holding kernel row ky; entry 0 is the newest row.
  function automatic logic [BankBits-1:0] win_row(input logic [KhBits-1:0] kh, input int ky);
    int r;
    r = 2 * int'(kh) - ky;
    if (r < 0) begin
      r = 0;
    end
    return BankBits'(r);
  endfunction

  // Bank of the row r rows above the bank given (rows rotate over the banks).
  function automatic logic [BankBits-1:0] bank_sel(input logic [BankBits-1:0] b, input int r);
    int t;
    t = int'(b) - r;
    if (t < 0) begin
      t = t + NumBanks;
    end
    return BankBits'(t);
  endfunction

endpackage

@@ rtl/core/image_convolution_2d_core.sv @@
// Top level of the streaming 2D convolution core with zero padding.
// Instantiates icv_front, icv_fifo, icv_window and icv_mac; depends on icv_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   input    | in_valid_i/in_ready_o  | action_i coef_index_i coef_value_i pixel_value_i
//   output   | out_valid_o/out_ready_i| result_value_o saturated_o frame_last_o
//   config   | cfg_we_i (no wait)     | cfg_idx_i cfg_wdata_i
//
// One word per clock sustained while the queue has room and no flush walks the window.
// After leaving the queue, a word passes the bank read, window shift, multiply, row sum,
// total and round registers. A flush on a frame smaller than the kernel lag first queues
// a window advance, holding in_ready_o low, for each window column it walks over before
// the result is queued. Reset clears counters, valids, registers and the coefficient
// table; the line store banks keep whatever they hold. Output stall freezes the whole
// back end; the 4-entry queue lets the front keep taking words meanwhile.
module image_convolution_2d_core import icv_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [CoefIdxBits-1:0]      coef_index_i,
  input  logic signed [CoefBits-1:0]  coef_value_i,
  input  logic signed [PixelBits-1:0] pixel_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [PixelBits-1:0] result_value_o,
  output logic                        saturated_o,
  output logic                        frame_last_o,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [CfgDataBits-1:0]      cfg_wdata_i
);

  logic [DimBits-1:0]   width_q, height_q;
  logic [KhBits-1:0]    khalf_q;
  logic [ShiftBits-1:0] shift_q;
  logic [DimBits-1:0]   width_eff, height_eff;
  cfg_idx_e             cfg_idx;
  logic                 restart;

  logic push, fifo_full, fifo_vld, adv, s2_vld;
  op_t  push_op, fifo_op, s2_op;
  win_t win;

  // configuration registers; a size or radius write restarts the frame
  assign cfg_idx = cfg_idx_e'(cfg_idx_i);
  assign restart = cfg_we_i && (cfg_idx != CFG_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      khalf_q  <= KhalfReset;
      shift_q  <= ShiftReset;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        CFG_KHALF:  khalf_q  <= cfg_wdata_i[KhBits-1:0];
        CFG_SHIFT:  shift_q  <= cfg_wdata_i[ShiftBits-1:0];
        default: ;
      endcase
    end
  end

  // zero size acts as one, oversize as the maximum
  always_comb begin
    width_eff = width_q;
    if (width_q == '0) begin
      width_eff = DimBits'(1);
    end else if (width_q > DimBits'(MaxWidth)) begin
      width_eff = DimBits'(MaxWidth);
    end
    height_eff = height_q;
    if (height_q == '0) begin
      height_eff = DimBits'(1);
    end else if (height_q > DimBits'(MaxHeight)) begin
      height_eff = DimBits'(MaxHeight);
    end
  end

  icv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .pixel_value_i (pixel_value_i),
    .width_i       (width_eff),
    .height_i      (height_eff),
    .khalf_i       (khalf_q),
    .restart_i     (restart),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .op_o          (push_op)
  );

  icv_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (adv),
    .full_o    (fifo_full),
    .vld_o     (fifo_vld),
    .op_o      (fifo_op)
  );

  icv_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .pop_vld_i (fifo_vld),
    .pop_op_i  (fifo_op),
    .s2_vld_o  (s2_vld),
    .s2_op_o   (s2_op),
    .win_o     (win)
  );

  icv_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s2_vld_i       (s2_vld),
    .s2_op_i        (s2_op),
    .win_i          (win),
    .khalf_i        (khalf_q),
    .shift_i        (shift_q),
    .adv_o          (adv),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .saturated_o    (saturated_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

@@ rtl/core/icv_front.sv @@
// Front end: classifies input words, tracks frame positions, queues operations.
// Depends on icv_pkg.
module icv_front import icv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             action_i,
  input  logic [CoefIdxBits-1:0] coef_index_i,
  input  logic [CoefBits-1:0]    coef_value_i,
  input  logic [PixelBits-1:0]   pixel_value_i,
  input  logic [DimBits-1:0]     width_i,
  input  logic [DimBits-1:0]     height_i,
  input  logic [KhBits-1:0]      khalf_i,
  input  logic                   restart_i,
  input  logic                   fifo_full_i,
  output logic                   push_o,
  output op_t                    op_o
);

  logic [ColBits-1:0]    in_col_q, in_col_d;
  logic [RowBits-1:0]    in_row_q, in_row_d;
  logic [PosBits-1:0]    nlin_q, nlin_d;
  logic [ColBits-1:0]    vcol_q, vcol_d;
  logic [BankBits-1:0]   vbank_q, vbank_d;
  logic [OutPosBits-1:0] olin_q, olin_d;
  logic [ColBits-1:0]    out_col_q, out_col_d;
  logic [ColBits-1:0]    out_row_q, out_row_d;

  action_e             act;
  logic                frame_in_done;
  logic [DelayBits-1:0] delay;
  logic [PosBits-1:0]  target;
  logic                n_ge;
  logic                bubble;
  logic                accept;
  logic                is_last;
  logic                adv;
  logic                emit;
  logic                pix_take;
  logic [DimBits:0]    ra, ca, kh_x, h_x, w_x;

  always_comb begin
    act           = action_e'(action_i);
    frame_in_done = in_row_q >= height_i;
    delay         = DelayBits'(khalf_i) * DelayBits'(width_i) + DelayBits'(khalf_i);
    target        = PosBits'(olin_q) + PosBits'(delay);
    n_ge          = nlin_q >= target;
    // flush that must first walk the window up to the next output position
    bubble        = in_valid_i && (act == ACT_FLUSH) && frame_in_done && !n_ge;
    in_ready_o    = !fifo_full_i && !bubble;
    accept        = in_valid_i && in_ready_o;
    is_last       = (DimBits'(out_row_q) == height_i - DimBits'(1)) &&
                    (DimBits'(out_col_q) == width_i - DimBits'(1));

    push_o   = 1'b0;
    adv      = 1'b0;
    emit     = 1'b0;
    pix_take = 1'b0;
    op_o     = '0;
    case (act)
      ACT_LOAD: begin
        if (accept) begin
          push_o     = 1'b1;
          op_o.is_load = 1'b1;
        end
      end
      ACT_PIXEL: begin
        if (accept && !frame_in_done) begin
          push_o   = 1'b1;
          adv      = 1'b1;
          pix_take = 1'b1;
          emit     = n_ge;
        end
      end
      ACT_FLUSH: begin
        if (accept && frame_in_done) begin
          push_o = 1'b1;
          adv    = 1'b1;
          emit   = 1'b1;
        end else if (bubble && !fifo_full_i) begin
          push_o = 1'b1;
          adv    = 1'b1;
        end
      end
      default: ;
    endcase

    op_o.is_adv   = adv;
    op_o.do_write = pix_take;
    op_o.emit     = emit;
    op_o.last     = emit && is_last;
    op_o.data     = (act == ACT_LOAD) ? coef_value_i : pixel_value_i;
    op_o.cidx     = coef_index_i;
    op_o.vcol     = vcol_q;
    op_o.vbank    = vbank_q;

    // padding masks: kernel row/col k is in the image when 0 <= pos - kh + k < size
    kh_x = (DimBits+1)'(khalf_i);
    h_x  = (DimBits+1)'(height_i);
    w_x  = (DimBits+1)'(width_i);
    for (int k = 0; k < MaxKernel; k++) begin
      ra = (DimBits+1)'(out_row_q) + (DimBits+1)'(k);
      ca = (DimBits+1)'(out_col_q) + (DimBits+1)'(k);
      op_o.row_mask[k] = (k <= 2 * int'(khalf_i)) && (ra >= kh_x) && (ra < h_x + kh_x);
      op_o.col_mask[k] = (k <= 2 * int'(khalf_i)) && (ca >= kh_x) && (ca < w_x + kh_x);
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    nlin_d    = nlin_q;
    vcol_d    = vcol_q;
    vbank_d   = vbank_q;
    olin_d    = olin_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (pix_take) begin
      if (DimBits'(in_col_q) + DimBits'(1) >= width_i) begin
        in_col_d = '0;
        in_row_d = in_row_q + RowBits'(1);
      end else begin
        in_col_d = in_col_q + ColBits'(1);
      end
    end
    if (adv) begin
      nlin_d = nlin_q + PosBits'(1);
      if (DimBits'(vcol_q) + DimBits'(1) >= width_i) begin
        vcol_d  = '0;
        vbank_d = (vbank_q == BankBits'(NumBanks - 1)) ? '0 : vbank_q + BankBits'(1);
      end else begin
        vcol_d = vcol_q + ColBits'(1);
      end
    end
    if (emit) begin
      olin_d = olin_q + OutPosBits'(1);
      if (DimBits'(out_col_q) + DimBits'(1) >= width_i) begin
        out_col_d = '0;
        out_row_d = out_row_q + ColBits'(1);
      end else begin
        out_col_d = out_col_q + ColBits'(1);
      end
    end
    if ((emit && is_last) || restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      nlin_d    = '0;
      vcol_d    = '0;
      vbank_d   = '0;
      olin_d    = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      nlin_q    <= '0;
      vcol_q    <= '0;
      vbank_q   <= '0;
      olin_q    <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      nlin_q    <= nlin_d;
      vcol_q    <= vcol_d;
      vbank_q   <= vbank_d;
      olin_q    <= olin_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

@@ rtl/core/icv_fifo.sv @@
// Short operation queue between front and back end.
// Depends on icv_pkg.
module icv_fifo import icv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  input  logic pop_i,
  output logic full_o,
  output logic vld_o,
  output op_t  op_o
);

  op_t                    mem_q [FifoDepth];
  logic [FifoPtrBits-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FifoCntBits-1:0] cnt_q, cnt_d;
  logic                   do_pop;

  always_comb begin
    full_o = cnt_q == FifoCntBits'(FifoDepth);
    vld_o  = cnt_q != '0;
    op_o   = mem_q[rptr_q];
    do_pop = pop_i && vld_o;
    wptr_d = push_i ? wptr_q + FifoPtrBits'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + FifoPtrBits'(1) : rptr_q;
    cnt_d  = cnt_q + FifoCntBits'(push_i) - FifoCntBits'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ rtl/core/icv_window.sv @@
// Line store banks and the sliding pixel window (back end stages 1 and 2).
// Depends on icv_pkg.
module icv_window import icv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic pop_vld_i,
  input  op_t  pop_op_i,
  output logic s2_vld_o,
  output op_t  s2_op_o,
  output win_t win_o
);

  logic                 s1_vld_q;
  op_t                  s1_op_q;
  logic [PixelBits-1:0] rd_data [NumBanks];
  logic                 mem_en;
  col_t                 col_new;
  win_t                 win_q, win_d;
  logic                 s2_vld_q;
  op_t                  s2_op_q;

  assign mem_en = adv_i && pop_vld_i && pop_op_i.is_adv;

  // one bank per image row modulo the largest kernel side, addressed by column
  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    logic [PixelBits-1:0] ram_q [MaxWidth];
    logic [PixelBits-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (mem_en) begin
        if (pop_op_i.do_write && (pop_op_i.vbank == BankBits'(b))) begin
          ram_q[pop_op_i.vcol] <= pop_op_i.data;
        end
        rd_q <= ram_q[pop_op_i.vcol];
      end
    end

    assign rd_data[b] = rd_q;
  end

  always_comb begin
    for (int r = 0; r < NumBanks; r++) begin
      col_new[r] = rd_data[bank_sel(s1_op_q.vbank, r)];
    end
    // newest row is the pixel written in the same cycle: bypass the bank
    if (s1_op_q.do_write) begin
      col_new[0] = s1_op_q.data;
    end
    for (int s = 0; s < MaxKernel - 1; s++) begin
      win_d[s] = win_q[s+1];
    end
    win_d[MaxKernel-1] = col_new;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_op_q <= pop_op_i;
      s2_op_q <= s1_op_q;
      if (s1_vld_q && s1_op_q.is_adv) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= pop_vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  assign s2_vld_o = s2_vld_q;
  assign s2_op_o  = s2_op_q;
  assign win_o    = win_q;

endmodule

@@ rtl/core/icv_mac.sv @@
// Coefficient table, 49 parallel multipliers, registered sum tree, rounding and
// saturation, and the output register. Depends on icv_pkg.
module icv_mac import icv_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s2_vld_i,
  input  op_t                         s2_op_i,
  input  win_t                        win_i,
  input  logic [KhBits-1:0]           khalf_i,
  input  logic [ShiftBits-1:0]        shift_i,
  output logic                        adv_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [PixelBits-1:0] result_value_o,
  output logic                        saturated_o,
  output logic                        frame_last_o
);

  logic signed [CoefBits-1:0]   coef_q [CoefDepth];
  logic signed [ProdBits-1:0]   prod_q [MaxKernel][MaxKernel];
  logic signed [ProdBits-1:0]   prod_d [MaxKernel][MaxKernel];
  logic signed [RowSumBits-1:0] rsum_q [MaxKernel];
  logic signed [RowSumBits-1:0] rsum_d [MaxKernel];
  logic signed [SumBits-1:0]    sum_q, sum_d;
  logic                         s3_vld_q, s4_vld_q, s5_vld_q;
  logic                         s3_last_q, s4_last_q, s5_last_q;
  logic                         out_valid_q;
  logic signed [PixelBits-1:0]  res_q, res_d;
  logic                         sat_q, sat_d;
  logic                         last_q;
  logic                         coef_we;
  logic signed [SumBits:0]      ext, rnd, shv;

  assign adv_o   = !out_valid_q || out_ready_i;
  assign coef_we = adv_o && s2_vld_i && s2_op_i.is_load &&
                   (s2_op_i.cidx < CoefIdxBits'(CoefDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CoefDepth; i++) begin
        coef_q[i] <= '0;
      end
    end else if (coef_we) begin
      coef_q[s2_op_i.cidx] <= s2_op_i.data;
    end
  end

  // products; positions outside the image contribute zero
  always_comb begin
    logic signed [PixelBits-1:0] pix;
    logic signed [CoefBits-1:0]  cf;
    for (int ky = 0; ky < MaxKernel; ky++) begin
      for (int kx = 0; kx < MaxKernel; kx++) begin
        pix = (s2_op_i.row_mask[ky] && s2_op_i.col_mask[kx]) ?
              win_i[win_slot(khalf_i, kx)][win_row(khalf_i, ky)] : '0;
        cf  = coef_q[coef_pos(khalf_i, ky, kx)];
        prod_d[ky][kx] = pix * cf;
      end
    end
  end

  always_comb begin
    for (int ky = 0; ky < MaxKernel; ky++) begin
      rsum_d[ky] = '0;
      for (int kx = 0; kx < MaxKernel; kx++) begin
        rsum_d[ky] = rsum_d[ky] + RowSumBits'(prod_q[ky][kx]);
      end
    end
    sum_d = '0;
    for (int ky = 0; ky < MaxKernel; ky++) begin
      sum_d = sum_d + SumBits'(rsum_q[ky]);
    end
  end

  // round half up, arithmetic shift, clip to the pixel range
  always_comb begin
    ext = (SumBits+1)'(sum_q);
    rnd = (shift_i == '0) ? '0 : ((SumBits+1)'(1) <<< (shift_i - ShiftBits'(1)));
    shv = (ext + rnd) >>> shift_i;
    sat_d = 1'b0;
    res_d = PixelBits'(shv);
    if (shv > (SumBits+1)'(PixMaxInt)) begin
      res_d = PixelBits'(PixMaxInt);
      sat_d = 1'b1;
    end else if (shv < (SumBits+1)'(PixMinInt)) begin
      res_d = PixelBits'(PixMinInt);
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      prod_q    <= prod_d;
      rsum_q    <= rsum_d;
      sum_q     <= sum_d;
      s3_last_q <= s2_op_i.last;
      s4_last_q <= s3_last_q;
      s5_last_q <= s4_last_q;
      res_q     <= res_d;
      sat_q     <= sat_d;
      last_q    <= s5_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      s3_vld_q    <= s2_vld_i && s2_op_i.emit;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      out_valid_q <= s5_vld_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign saturated_o    = sat_q;
  assign frame_last_o   = last_q;

endmodule

@@ rtl/core/icv_checker.sv @@
// Port-level checks for the convolution core, bound to the top level.
// Depends on icv_pkg for the pixel width.
module icv_checker import icv_pkg::*; (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [PixelBits-1:0] result_value_o,
  input logic                        saturated_o,
  input logic                        frame_last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o) &&
                                    $stable(saturated_o) && $stable(frame_last_o))
    else $error("result changed while stalled");

  // a clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (result_value_o == PixelBits'(PixMaxInt)) || (result_value_o == PixelBits'(PixMinInt)))
    else $error("saturated result not at a limit");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind image_convolution_2d_core icv_checker u_icv_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for image_convolution_2d_core: a directed table, then random frames.
// Holds its own convolution predictor; depends on icv_pkg and the core RTL only.
module tb_top import icv_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HistDepth = (MaxKernel - 1) * MaxWidth + MaxKernel;
  localparam int DrainWait = 64;    // back end depth plus flush column walk
  localparam int StallLimit = 4000; // cycles with no word moving on either side

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_NOP;
  logic [CoefIdxBits-1:0] coef_index = '0;
  logic signed [CoefBits-1:0] coef_value = '0;
  logic signed [PixelBits-1:0] pixel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PixelBits-1:0] result_value;
  logic saturated, frame_last;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  image_convolution_2d_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .coef_index_i(coef_index),
    .coef_value_i(coef_value), .pixel_value_i(pixel_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_value_o(result_value), .saturated_o(saturated), .frame_last_o(frame_last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  typedef struct {
    logic signed [PixelBits-1:0] value;
    logic sat;
    logic last;
  } pixel_out_t;

  pixel_out_t pending_pixels[$];
  int errors = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Convolution predictor: shadow registers, coefficient table, pixel history
  // ---------------------------------------------------------------------------
  logic [DimBits-1:0] width_reg, height_reg;
  logic [KhBits-1:0] khalf_reg;
  logic [ShiftBits-1:0] shift_reg;
  logic signed [CoefBits-1:0] coefs[CoefDepth];
  logic signed [PixelBits-1:0] history[HistDepth];
  int unsigned in_col, in_row, out_col, out_row;

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    return (width_reg > MaxWidth) ? MaxWidth : width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    return (height_reg > MaxHeight) ? MaxHeight : height_reg;
  endfunction

  function automatic void restart_counts();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic void shadow_reset();
    foreach (coefs[i]) coefs[i] = '0;
    width_reg = WidthReset; height_reg = HeightReset;
    khalf_reg = KhalfReset; shift_reg = ShiftReset;
    restart_counts();
  endfunction

  function automatic void shadow_cfg(cfg_idx_e idx, logic [CfgDataBits-1:0] data);
    case (idx)
      CFG_WIDTH: begin width_reg = data; restart_counts(); end
      CFG_HEIGHT: begin height_reg = data; restart_counts(); end
      CFG_KHALF: begin khalf_reg = data[KhBits-1:0]; restart_counts(); end
      default: shift_reg = data[ShiftBits-1:0];
    endcase
  endfunction

  // Window sum around the current output position, rounded and clipped.
  function automatic pixel_out_t conv_pixel();
    pixel_out_t r;
    int unsigned w, h, kh, side;
    longint acc, v, iy, ix;
    w = eff_w(); h = eff_h(); kh = khalf_reg; side = 2 * kh + 1;
    acc = 0;
    for (int ky = 0; ky < side; ky++) begin
      for (int kx = 0; kx < side; kx++) begin
        iy = longint'(out_row) + ky - kh;
        ix = longint'(out_col) + kx - kh;
        if (iy >= 0 && iy < h && ix >= 0 && ix < w) begin
          acc += longint'(history[(iy * w + ix) % HistDepth]) * longint'(coefs[ky * side + kx]);
        end
      end
    end
    v = acc;
    if (shift_reg != 0) v = (acc + (longint'(1) << (shift_reg - 1))) >>> shift_reg;
    r.sat = 1'b0;
    if (v > PixMaxInt) begin v = PixMaxInt; r.sat = 1'b1; end
    if (v < PixMinInt) begin v = PixMinInt; r.sat = 1'b1; end
    r.value = PixelBits'(v);
    r.last = (out_row == h - 1 && out_col == w - 1);
    if (r.last) begin
      restart_counts();
    end else if (++out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    return r;
  endfunction

  // Returns 1 and fills r when the accepted word yields an output pixel.
  function automatic bit conv_word(logic [1:0] act, logic [CoefIdxBits-1:0] ci,
                                   logic signed [CoefBits-1:0] cv,
                                   logic signed [PixelBits-1:0] pv, output pixel_out_t r);
    int unsigned w, h;
    longint got, lag;
    w = eff_w(); h = eff_h();
    r = '{default: '0};
    case (act)
      ACT_LOAD: begin
        if (ci < CoefDepth) coefs[ci] = cv;
        return 0;
      end
      ACT_PIXEL: begin
        if (in_row >= h) return 0;  // frame already fully in
        got = longint'(in_row) * w + in_col;
        history[got % HistDepth] = pv;
        if (++in_col >= w) begin in_col = 0; in_row++; end
        lag = longint'(khalf_reg) * w + khalf_reg;
        if (got + 1 >= longint'(out_row) * w + out_col + lag + 1) begin
          r = conv_pixel();
          return 1;
        end
        return 0;
      end
      ACT_FLUSH: begin
        if (in_row < h) return 0;   // early flush does nothing
        r = conv_pixel();
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  bit in_fire, out_fire;
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Offer one word; typed means the expected pixel is typed_px, not the predictor's.
  task automatic send_word(logic [1:0] act, logic [CoefIdxBits-1:0] ci,
                           logic signed [CoefBits-1:0] cv, logic signed [PixelBits-1:0] pv,
                           bit typed = 0, pixel_out_t typed_px = '{default: '0});
    pixel_out_t px;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act; coef_index <= ci; coef_value <= cv; pixel_value <= pv;
    do @(posedge clk); while (!in_ready);
    if (conv_word(act, ci, cv, pv, px)) begin
      pending_pixels.push_back(typed ? typed_px : px);
    end
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataBits-1:0] data);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg(idx, data);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, long hold-off on request, in-order compare
  // ---------------------------------------------------------------------------
  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_fire) begin
        if (pending_pixels.size() == 0) begin
          report("unexpected word, value", result_value, 0);
        end else begin
          pixel_out_t e;
          e = pending_pixels.pop_front();
          if (result_value !== e.value) report("result_value", result_value, e.value);
          if (saturated !== e.sat) report("saturated", saturated, e.sat);
          if (frame_last !== e.last) report("frame_last", frame_last, e.last);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no word moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      quiet = (in_fire || out_fire) ? 0 : quiet + 1;
      if (quiet >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit is_cfg;
    cfg_idx_e idx;
    logic [CfgDataBits-1:0] data;
    logic [1:0] act;
    logic [CoefIdxBits-1:0] ci;
    logic [15:0] cv;
    logic [15:0] pv;
    bit typed;
    pixel_out_t px;
  } row_t;

  row_t rows[$];

  function automatic void add_cfg(cfg_idx_e idx, int data);
    rows.push_back('{is_cfg: 1, idx: idx, data: CfgDataBits'(data), act: ACT_NOP,
                     ci: 0, cv: 0, pv: 0, typed: 0, px: '{default: '0}});
  endfunction

  function automatic void add_word(logic [1:0] act, int ci, logic [15:0] cv, logic [15:0] pv,
                                   bit typed = 0, logic [15:0] ev = 0, bit es = 0, bit el = 0);
    rows.push_back('{is_cfg: 0, idx: CFG_WIDTH, data: 0, act: act, ci: CoefIdxBits'(ci),
                     cv: cv, pv: pv, typed: typed, px: '{value: ev, sat: es, last: el}});
  endfunction

  function automatic void build_rows();
    // 1x1 frame, single tap, no shift: output equals pixel times coefficient
    add_cfg(CFG_WIDTH, 1); add_cfg(CFG_HEIGHT, 1); add_cfg(CFG_KHALF, 0); add_cfg(CFG_SHIFT, 0);
    add_word(ACT_LOAD, 0, 16'h0001, 0);
    add_word(ACT_PIXEL, 0, 0, 16'h7FFF, 1, 16'h7FFF, 0, 1);
    add_word(ACT_PIXEL, 0, 0, 16'h8000, 1, 16'h8000, 0, 1);
    add_word(ACT_LOAD, 0, 16'h8000, 0);
    add_word(ACT_PIXEL, 0, 0, 16'h8000, 1, 16'h7FFF, 1, 1);  // clips high
    add_word(ACT_PIXEL, 0, 0, 16'h7FFF, 1, 16'h8000, 1, 1);  // clips low
    add_word(ACT_LOAD, 63, 16'h1234, 0);                      // index off the table
    add_word(ACT_NOP, 0, 0, 16'h0005);                        // no-op action
    add_word(ACT_FLUSH, 0, 0, 0);                             // flush before any pixel
    // largest shift rounds a big positive sum down to zero
    add_cfg(CFG_SHIFT, 31);
    add_word(ACT_LOAD, 0, 16'h7FFF, 0);
    add_word(ACT_PIXEL, 0, 0, 16'h7FFF, 1, 16'h0000, 0, 1);
    // 3x2 frame with a 3x3 kernel: padding, early flush, excess pixel, drain
    add_cfg(CFG_WIDTH, 3); add_cfg(CFG_HEIGHT, 2); add_cfg(CFG_KHALF, 1); add_cfg(CFG_SHIFT, 14);
    add_word(ACT_LOAD, 4, 16'h4000, 0);
    add_word(ACT_LOAD, 48, 16'h7FFF, 0);
    add_word(ACT_LOAD, 1, 16'hC000, 0);
    add_word(ACT_PIXEL, 0, 0, 16'h0100);
    add_word(ACT_PIXEL, 0, 0, 16'h8000);
    add_word(ACT_FLUSH, 0, 0, 0);
    for (int i = 0; i < 4; i++) add_word(ACT_PIXEL, 0, 0, 16'(i * 3001 - 4000));
    add_word(ACT_PIXEL, 0, 0, 16'h7FFF);                      // frame already in
    for (int i = 0; i < 4; i++) add_word(ACT_FLUSH, 0, 0, 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Random frames
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] rand_sample();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(4095)) - 2048);
  endfunction

  task automatic random_noise();
    case ($urandom_range(2))
      0: send_word(ACT_NOP, 6'($urandom), 16'($urandom), 16'($urandom));
      1: send_word(ACT_FLUSH, 6'($urandom), 16'($urandom), 16'($urandom));
      default: send_word(ACT_LOAD, 6'($urandom_range(63, CoefDepth)), 16'($urandom), 0);
    endcase
  endtask

  // Coefficient loads, a full frame of pixels, then flushes until it drains.
  task automatic random_frame(ref int count);
    int loads;
    int npix;
    loads = $urandom_range(8);
    repeat (loads) begin
      send_word(ACT_LOAD, 6'($urandom_range(63)), rand_sample(), 16'($urandom));
      count++;
    end
    npix = eff_w() * eff_h();
    repeat (npix) begin
      if ($urandom_range(99) < 4) random_noise();
      send_word(ACT_PIXEL, 6'($urandom), 16'($urandom), rand_sample());
      count++;
    end
    if ($urandom_range(3) == 0) send_word(ACT_PIXEL, 0, 0, rand_sample());  // ignored
    while (in_row >= eff_h()) begin
      send_word(ACT_FLUSH, 6'($urandom), 16'($urandom), 16'($urandom));
      count++;
    end
  endtask

  initial begin
    int count;
    int phase;
    int w, h;
    bit wide;
    bit wide_done;
    shadow_reset();
    foreach (history[i]) history[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    build_rows();
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain_wait();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_word(rows[i].act, rows[i].ci, rows[i].cv, rows[i].pv, rows[i].typed, rows[i].px);
      end
    end

    count = 0;
    phase = 0;
    wide_done = 1'b0;
    while (count < 1300) begin
      // idling pattern: sender light/receiver heavy, then swapped, then none
      if (count < 140) begin
        in_idle_pct = 18; out_idle_pct = 74;
      end else if (count < 280) begin
        in_idle_pct = 74; out_idle_pct = 18;
      end else begin
        in_idle_pct = 0; out_idle_pct = 0;
      end
      drain_wait();
      wide = (count >= 280) && !wide_done;
      if (wide) begin
        w = 2047; h = 1;                   // widest row, clamped to the maximum
      end else begin
        case (phase)
          1: begin w = 1; h = 48; end      // one-pixel column under the largest kernel
          2: begin w = 0; h = 0; end       // zero sizes act as one
          default: begin
            w = $urandom_range(12, 1);
            h = $urandom_range(6, 1);
          end
        endcase
      end
      write_reg(CFG_WIDTH, CfgDataBits'(w));
      write_reg(CFG_HEIGHT, CfgDataBits'(h));
      if (wide) begin
        // single tap: every pixel yields a result at once
        write_reg(CFG_KHALF, CfgDataBits'(0));
      end else begin
        write_reg(CFG_KHALF, (phase == 1) ? CfgDataBits'(3) : CfgDataBits'($urandom));
      end
      write_reg(CFG_SHIFT, $urandom_range(1) ? CfgDataBits'($urandom)
                                             : CfgDataBits'($urandom_range(16, 10)));
      if (wide) begin
        // long receiver hold-off while the wide row streams in
        in_idle_pct = 0;
        hold_req = 1'b1;
        random_frame(count);
        wide_done = 1'b1;
      end else begin
        repeat ($urandom_range(3, 1)) random_frame(count);
        phase++;
      end
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
